FILE: src/tocs_pkg.sv
// Shared types and codes for the time-ordered command scheduler.
// No dependencies; every other file imports this package.
package tocs_pkg;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_IDLE     = 3'd0,
    KIND_ADDED    = 3'd1,
    KIND_DROPPED  = 3'd2,
    KIND_REJECTED = 3'd3,
    KIND_CLEARED  = 3'd4,
    KIND_RELEASED = 3'd5
  } kind_e;

  localparam logic [0:0] REG_SCHED_EN = 1'b0;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] exec_time;
    logic [31:0] body_high;
    logic [63:0] body_low;
    logic [31:0] present_time;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] out_time;
    logic [31:0] out_body_high;
    logic [63:0] out_body_low;
    logic [8:0]  entries_held;
  } res_word_t;

  typedef struct packed {
    logic [31:0] exec_time;
    logic [31:0] body_high;
    logic [63:0] body_low;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_SHIFT,
    ST_INS_HEAD,
    ST_POP_CHECK
  } state_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_LAST,
    RD_HEAD,
    RD_NEXT
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_NEW_ABOVE,
    WR_NEW_ZERO
  } wr_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_CLEAR,
    CNT_POP
  } cnt_op_e;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    cnt_op_e cnt_op;
    logic    res_load;
    kind_e   res_kind;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic later;   // entry just read sorts after the new one
    logic due;     // entry just read is not after the present time
    logic j_zero;
    logic j_top;
  } status_t;

endpackage

FILE: src/tocs_dp.sv
// Datapath of the scheduler: circular entry memory, head and count, scan index,
// result register. Depends on tocs_pkg; steered by tocs_ctrl.
module tocs_dp #(
  parameter int unsigned SCHEDULE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tocs_pkg::cmd_word_t cmd_i,
  input  tocs_pkg::ctrl_t     ctrl_i,
  output tocs_pkg::status_t   status_o,
  output tocs_pkg::res_word_t res_o,
  output logic                done_o
);
  import tocs_pkg::*;

  localparam int unsigned AW = (SCHEDULE_DEPTH > 1) ? $clog2(SCHEDULE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SCHEDULE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A  = (AW + 1)'(SCHEDULE_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(SCHEDULE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(SCHEDULE_DEPTH);

  entry_t          mem_q [SCHEDULE_DEPTH];
  entry_t          new_q, rd_q, wr_data;
  logic [31:0]     now_q;
  logic [AW-1:0]   head_q, head_d, j_q, j_d;
  logic [CW-1:0]   count_q, count_d, cnt_m1;
  res_word_t       res_q, res_d;
  logic            done_q;
  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_log, wr_log, rd_addr, wr_addr;

  // logical position -> physical row, wrapping past the end
  function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                              input logic [AW-1:0] ofs);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= DEPTH_A) sum = sum - DEPTH_A;
    return sum[AW-1:0];
  endfunction

  assign cnt_m1 = count_q - CW'(1);

  always_comb begin
    rd_en  = 1'b0;
    rd_log = '0;
    j_d    = j_q;
    case (ctrl_i.rd_sel)
      RD_LAST: begin
        rd_en  = 1'b1;
        rd_log = cnt_m1[AW-1:0];
        j_d    = rd_log;
      end
      RD_HEAD: begin
        rd_en  = 1'b1;
        rd_log = '0;
      end
      RD_NEXT: begin
        rd_en  = 1'b1;
        rd_log = j_q - AW'(1);
        j_d    = rd_log;
      end
      default: ;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_log  = '0;
    wr_data = new_q;
    case (ctrl_i.wr_sel)
      WR_SHIFT: begin
        wr_en   = 1'b1;
        wr_log  = j_q + AW'(1);
        wr_data = rd_q;
      end
      WR_NEW_ABOVE: begin
        wr_en  = 1'b1;
        wr_log = j_q + AW'(1);
      end
      WR_NEW_ZERO: begin
        wr_en  = 1'b1;
        wr_log = '0;
      end
      default: ;
    endcase
  end

  assign rd_addr = phys_addr(head_q, rd_log);
  assign wr_addr = phys_addr(head_q, wr_log);

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    case (ctrl_i.cnt_op)
      CNT_INC:   count_d = count_q + CW'(1);
      CNT_CLEAR: count_d = '0;
      CNT_POP: begin
        count_d = cnt_m1;
        head_d  = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    res_d              = '0;
    res_d.result_kind  = ctrl_i.res_kind;
    res_d.entries_held = 9'(count_d);
    if (ctrl_i.res_kind == KIND_RELEASED) begin
      res_d.out_time      = rd_q.exec_time;
      res_d.out_body_high = rd_q.body_high;
      res_d.out_body_low  = rd_q.body_low;
    end
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      new_q.exec_time <= cmd_i.exec_time;
      new_q.body_high <= cmd_i.body_high;
      new_q.body_low  <= cmd_i.body_low;
      now_q           <= cmd_i.present_time;
    end
    if (ctrl_i.res_load) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      j_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      j_q     <= j_d;
      done_q  <= ctrl_i.res_load;
    end
  end

  assign status_o.empty  = (count_q == '0);
  assign status_o.full   = (count_q == DEPTH_C);
  assign status_o.later  = (rd_q.exec_time > new_q.exec_time);
  assign status_o.due    = (rd_q.exec_time <= now_q);
  assign status_o.j_zero = (j_q == '0);
  assign status_o.j_top  = (j_q == LAST_IDX);

  assign res_o  = res_q;
  assign done_o = done_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count beyond depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= LAST_IDX)
    else $error("head pointer out of range");

  a_release_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.result_kind == KIND_RELEASED) |->
      (count_q == $past(count_q) - CW'(1)))
    else $error("release without pop");

endmodule

FILE: src/tocs_ctrl.sv
// Controller of the scheduler: state machine that sequences insert scans,
// head release and clear. Depends on tocs_pkg; drives tocs_dp.
module tocs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        op_i,
  input  logic              enable_i,
  input  tocs_pkg::status_t status_i,
  output tocs_pkg::ctrl_t   ctrl_o,
  output logic              busy_o
);
  import tocs_pkg::*;

  state_e state_q, state_d;
  kind_e  add_kind;
  cnt_op_e add_cnt;

  // store already full: latest entry falls off, count stays
  assign add_kind = status_i.full ? KIND_DROPPED : KIND_ADDED;
  assign add_cnt  = status_i.full ? CNT_HOLD : CNT_INC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    ctrl_o          = '0;
    ctrl_o.rd_sel   = RD_NONE;
    ctrl_o.wr_sel   = WR_NONE;
    ctrl_o.cnt_op   = CNT_HOLD;
    ctrl_o.res_kind = KIND_IDLE;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.capture = 1'b1;
          case (op_i)
            OP_ADD: begin
              if (status_i.empty) begin
                state_d = ST_INS_HEAD;
              end else begin
                ctrl_o.rd_sel = RD_LAST;
                state_d       = ST_INS_SHIFT;
              end
            end
            OP_CLEAR: begin
              ctrl_o.cnt_op   = CNT_CLEAR;
              ctrl_o.res_load = 1'b1;
              ctrl_o.res_kind = KIND_CLEARED;
            end
            OP_TICK: begin
              if (enable_i && !status_i.empty) begin
                ctrl_o.rd_sel = RD_HEAD;
                state_d       = ST_POP_CHECK;
              end else begin
                ctrl_o.res_load = 1'b1;
              end
            end
            default: ctrl_o.res_load = 1'b1;
          endcase
        end
      end
      ST_INS_SHIFT: begin
        if (status_i.later) begin
          if (!status_i.j_top) ctrl_o.wr_sel = WR_SHIFT;
          if (status_i.j_zero) begin
            state_d = ST_INS_HEAD;
          end else begin
            ctrl_o.rd_sel = RD_NEXT;
          end
        end else if (status_i.j_top) begin
          ctrl_o.res_load = 1'b1;
          ctrl_o.res_kind = KIND_REJECTED;
          state_d         = ST_IDLE;
        end else begin
          ctrl_o.wr_sel   = WR_NEW_ABOVE;
          ctrl_o.cnt_op   = add_cnt;
          ctrl_o.res_load = 1'b1;
          ctrl_o.res_kind = add_kind;
          state_d         = ST_IDLE;
        end
      end
      ST_INS_HEAD: begin
        ctrl_o.wr_sel   = WR_NEW_ZERO;
        ctrl_o.cnt_op   = add_cnt;
        ctrl_o.res_load = 1'b1;
        ctrl_o.res_kind = add_kind;
        state_d         = ST_IDLE;
      end
      ST_POP_CHECK: begin
        ctrl_o.res_load = 1'b1;
        if (status_i.due) begin
          ctrl_o.cnt_op   = CNT_POP;
          ctrl_o.res_kind = KIND_RELEASED;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  a_scan_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_SHIFT || state_q == ST_POP_CHECK) |-> !status_i.empty)
    else $error("scan running on empty store");

endmodule

FILE: src/time_ordered_command_scheduler_core.sv
// Top level of the time-ordered command scheduler: APB register, controller
// and datapath. Depends on tocs_pkg, tocs_ctrl and tocs_dp.
//
// Usage: a command word is taken at a clock edge where start is high and busy
// is low. Every command yields exactly one result word, shown on rsp_o for a
// single cycle with done_o high; the receiver cannot stall it, so capture it
// then. Entries are held in time order in a circular memory (head pointer plus
// count), so a due release only advances the head. Clear and an ignored code
// load their result at the accepting edge, as does a tick when paused or empty;
// any other tick first does one registered read of the head. An add to a
// non-empty store scans from the tail, moving each entry that sorts after the
// new one up one row per cycle through the memory's single read and single
// write port. busy stays high until the result is shown, and the next command
// may start on the cycle the result appears. The memory needs no clearing pass
// after reset.
// Register 0 (byte address 0, bit 0): scheduling enable, reset value 1.
module time_ordered_command_scheduler_core #(
  parameter int unsigned SCHEDULE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  tocs_pkg::cmd_word_t cmd_i,
  output logic                done_o,
  output tocs_pkg::res_word_t rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import tocs_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    sched_en_q;
  logic    reg_wr;

  // APB: zero wait states; word index is paddr[2]
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SCHED_EN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_en_q <= 1'b1;
    end else if (reg_wr) begin
      sched_en_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_SCHED_EN) ? {31'b0, sched_en_q} : 32'b0;

  tocs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .op_i     (cmd_i.operation),
    .enable_i (sched_en_q),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  tocs_dp #(
    .SCHEDULE_DEPTH (SCHEDULE_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .ctrl_i   (ctrl),
    .status_o (status),
    .res_o    (rsp_o),
    .done_o   (done_o)
  );

endmodule
